FILE: rtl/hbrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbrle_pkg;

    // Default row length in columns.
    localparam int ROW_PIXELS_DEF = 160;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Byte codes of the terminal stream.
    localparam logic [7:0] CHR_ESC   = 8'h1B;
    localparam logic [7:0] CHR_LBRK  = 8'h5B;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_TWO   = 8'h32;
    localparam logic [7:0] CHR_THREE = 8'h33;
    localparam logic [7:0] CHR_FOUR  = 8'h34;
    localparam logic [7:0] CHR_EIGHT = 8'h38;
    localparam logic [7:0] CHR_M     = 8'h6D;
    localparam logic [7:0] CHR_BLK0  = 8'hE2;
    localparam logic [7:0] CHR_BLK1  = 8'h96;
    localparam logic [7:0] CHR_BLK2  = 8'h80;
    localparam logic [7:0] CHR_NL    = 8'h0A;

    // Steps of the output program.
    localparam logic [4:0] STEP_ESC     = 5'd0;
    localparam logic [4:0] STEP_BLK     = 5'd24;
    localparam logic [4:0] STEP_BLK_END = 5'd26;
    localparam logic [4:0] STEP_NL      = 5'd27;

    // Channel indexes into the digit array of a command.
    localparam logic [2:0] CH_UR = 3'd0;
    localparam logic [2:0] CH_UG = 3'd1;
    localparam logic [2:0] CH_UB = 3'd2;
    localparam logic [2:0] CH_LR = 3'd3;
    localparam logic [2:0] CH_LG = 3'd4;
    localparam logic [2:0] CH_LB = 3'd5;

    // One input item: a vertical pixel pair.
    typedef struct packed {
        logic [7:0] upper_red;
        logic [7:0] upper_green;
        logic [7:0] upper_blue;
        logic [7:0] upper_alpha;
        logic [7:0] lower_red;
        logic [7:0] lower_green;
        logic [7:0] lower_blue;
        logic [7:0] lower_alpha;
        logic       row_end;
        logic       frame_end;
    } t_pix;

    // One result item: a byte of the stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       item_done;
    } t_obyte;

    // Decimal form of one channel, digits left aligned, most significant first.
    typedef struct packed {
        logic [1:0]       cnt;
        logic [2:0][3:0]  d;
    } t_dec;

    // Command handed from the front to the back.
    typedef struct packed {
        t_dec [5:0] dig;
        logic       run_open;
        logic       newline;
    } t_cmd;

    // One step of the output program.
    typedef struct packed {
        logic       is_dig;
        logic [2:0] chan;
        logic [7:0] chr;
    } t_slot;

    // Splits an 8-bit value into decimal digits without leading zeros.
    function automatic t_dec dec_split(input logic [7:0] v);
        t_dec       res;
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] o;
        logic [7:0] r;
        logic [7:0] q;
        h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
        r = v - 8'(h * 8'd100);
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= 8'(k * 10)) begin
                t = 4'(k);
            end
        end
        q = r - 8'(t * 8'd10);
        o = q[3:0];
        res.d = '0;
        if (v >= 8'd100) begin
            res.cnt  = 2'd3;
            res.d[0] = h;
            res.d[1] = t;
            res.d[2] = o;
        end else if (v >= 8'd10) begin
            res.cnt  = 2'd2;
            res.d[0] = t;
            res.d[1] = o;
        end else begin
            res.cnt  = 2'd1;
            res.d[0] = o;
        end
        return res;
    endfunction

    // Output program: escape, colors, half block, newline.
    function automatic t_slot slot_at(input logic [4:0] step);
        t_slot s;
        s = '{is_dig: 1'b0, chan: CH_UR, chr: CHR_SEMI};
        case (step)
            5'd0:    s.chr = CHR_ESC;
            5'd1:    s.chr = CHR_LBRK;
            5'd2:    s.chr = CHR_THREE;
            5'd3:    s.chr = CHR_EIGHT;
            5'd5:    s.chr = CHR_TWO;
            5'd7:    begin s.is_dig = 1'b1; s.chan = CH_UR; end
            5'd9:    begin s.is_dig = 1'b1; s.chan = CH_UG; end
            5'd11:   begin s.is_dig = 1'b1; s.chan = CH_UB; end
            5'd13:   s.chr = CHR_FOUR;
            5'd14:   s.chr = CHR_EIGHT;
            5'd16:   s.chr = CHR_TWO;
            5'd18:   begin s.is_dig = 1'b1; s.chan = CH_LR; end
            5'd20:   begin s.is_dig = 1'b1; s.chan = CH_LG; end
            5'd22:   begin s.is_dig = 1'b1; s.chan = CH_LB; end
            5'd23:   s.chr = CHR_M;
            5'd24:   s.chr = CHR_BLK0;
            5'd25:   s.chr = CHR_BLK1;
            5'd26:   s.chr = CHR_BLK2;
            5'd27:   s.chr = CHR_NL;
            default: s.chr = CHR_SEMI;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hbrle_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel carrying one item of type T per handshake.
interface hbrle_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hbrle_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hbrle_front
    import hbrle_pkg::*;
#(
    parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hbrle_stream_if.sink     i_pix,
    hbrle_stream_if.source   o_cmd
);

    localparam int CW = $clog2(ROW_PIXELS + 1);
    localparam logic [CW-1:0] COL_LAST = CW'(ROW_PIXELS - 1);

    logic [31:0]   r_upper;
    logic [31:0]   r_lower;
    logic          r_row_start;
    logic [CW-1:0] r_col;
    logic [31:0]   n_upper;
    logic [31:0]   n_lower;
    logic          n_row_start;
    logic [CW-1:0] n_col;
    logic          w_accept;
    logic          w_row_end;
    t_pix          w_p;
    t_cmd          w_cmd;

    // The front passes the handshake through to the queue.
    assign w_p         = i_pix.data;
    assign i_pix.ready = o_cmd.ready;
    assign o_cmd.valid = i_pix.valid;
    assign o_cmd.data  = w_cmd;
    assign w_accept    = i_pix.valid && o_cmd.ready;

    // Classify the item: run opening, row end, and decimal digits.
    always_comb begin
        n_upper = {w_p.upper_alpha, w_p.upper_blue, w_p.upper_green, w_p.upper_red};
        n_lower = {w_p.lower_alpha, w_p.lower_blue, w_p.lower_green, w_p.lower_red};
        w_row_end = w_p.row_end || w_p.frame_end || (r_col == COL_LAST);
        w_cmd.run_open   = r_row_start || (n_upper != r_upper) || (n_lower != r_lower);
        w_cmd.newline    = w_row_end && !w_p.frame_end;
        w_cmd.dig[CH_UR] = dec_split(w_p.upper_red);
        w_cmd.dig[CH_UG] = dec_split(w_p.upper_green);
        w_cmd.dig[CH_UB] = dec_split(w_p.upper_blue);
        w_cmd.dig[CH_LR] = dec_split(w_p.lower_red);
        w_cmd.dig[CH_LG] = dec_split(w_p.lower_green);
        w_cmd.dig[CH_LB] = dec_split(w_p.lower_blue);
        n_row_start = w_row_end;
        n_col       = w_row_end ? '0 : r_col + CW'(1);
    end

    // Held colors and row position advance on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= '0;
            r_lower     <= '0;
            r_row_start <= 1'b1;
            r_col       <= '0;
        end else if (w_accept) begin
            r_upper     <= n_upper;
            r_lower     <= n_lower;
            r_row_start <= n_row_start;
            r_col       <= n_col;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hbrle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hbrle_fifo
    import hbrle_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    hbrle_stream_if.sink     i_cmd,
    hbrle_stream_if.source   o_cmd
);

    localparam int AW = $clog2(Q_DEPTH);
    localparam logic [AW:0] FULL = (AW + 1)'(Q_DEPTH);

    t_cmd          r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [AW:0]   n_cnt;
    logic          w_push;
    logic          w_pop;

    assign i_cmd.ready = (r_cnt != FULL);
    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.data  = r_mem[r_rd];
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign w_pop       = o_cmd.valid && o_cmd.ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = w_push ? r_wr + AW'(1) : r_wr;
        n_rd  = w_pop ? r_rd + AW'(1) : r_rd;
        n_cnt = r_cnt + (AW + 1)'(w_push) - (AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd.data;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("queue fill count out of range");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + (AW + 1)'(1)))
        else $error("queue count missed a push");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == FULL) |-> !w_push)
        else $error("item pushed into a full queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/hbrle_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hbrle_back
    import hbrle_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    hbrle_stream_if.sink     i_cmd,
    hbrle_stream_if.source   o_byte
);

    logic       r_busy;
    logic [4:0] r_step;
    logic [1:0] r_dig;
    t_cmd       r_cmd;
    logic       r_ovalid;
    t_obyte     r_obyte;
    logic       n_busy;
    logic [4:0] n_step;
    logic [1:0] n_dig;
    logic       n_ovalid;
    t_slot      w_slot;
    t_dec       w_dec;
    logic       w_dig_last;
    logic       w_last;
    logic       w_adv;
    logic       w_fire;
    logic       w_load;
    logic       w_take;
    logic [7:0] w_byte;

    // Decode the current program step into a byte.
    always_comb begin
        w_slot     = slot_at(r_step);
        w_dec      = r_cmd.dig[w_slot.chan];
        w_dig_last = (r_dig == w_dec.cnt - 2'd1);
        w_byte     = w_slot.is_dig ? (CHR_ZERO + {4'd0, w_dec.d[r_dig]}) : w_slot.chr;
        w_last     = (r_step == (r_cmd.newline ? STEP_NL : STEP_BLK_END));
        w_adv      = !r_ovalid || o_byte.ready;
        w_fire     = r_busy && w_adv;
        w_load     = !r_busy || (w_fire && w_last);
        w_take     = w_load && i_cmd.valid;
    end

    assign i_cmd.ready  = w_load;
    assign o_byte.valid = r_ovalid;
    assign o_byte.data  = r_obyte;

    // Sequencer next state: load a command, walk its steps and digits.
    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_dig    = r_dig;
        n_ovalid = r_ovalid;
        if (w_fire) begin
            n_ovalid = 1'b1;
        end else if (o_byte.ready) begin
            n_ovalid = 1'b0;
        end
        if (w_take) begin
            n_busy = 1'b1;
            n_step = i_cmd.data.run_open ? STEP_ESC : STEP_BLK;
            n_dig  = 2'd0;
        end else if (w_fire) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else if (!w_slot.is_dig || w_dig_last) begin
                n_step = r_step + 5'd1;
                n_dig  = 2'd0;
            end else begin
                n_dig = r_dig + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= STEP_ESC;
            r_dig    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_step   <= n_step;
            r_dig    <= n_dig;
            r_ovalid <= n_ovalid;
        end
    end

    // Current command and output byte register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= i_cmd.data;
        end
        if (w_fire) begin
            r_obyte.out_byte  <= w_byte;
            r_obyte.item_done <= w_last;
        end
    end

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_NL))
        else $error("sequencer step out of range");
    a_done_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obyte.item_done) |->
            (r_obyte.out_byte == CHR_BLK2 || r_obyte.out_byte == CHR_NL))
        else $error("item closed on a wrong byte");
    a_load_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |-> (!r_busy || (w_fire && w_last)))
        else $error("command taken while another is in progress");
`endif

endmodule

`default_nettype wire

FILE: rtl/half_block_ansi_rle_encoder.sv
// The first byte of an item becomes valid after it has passed the queue entry, the
// sequencer's command and step registers and the output byte register, when the queue is empty and the output is free.
// Throughput: one byte per cycle while the receiver is ready, so an item is 3 to 40 bytes,
// made by the byte sequencer and its output register; a two-entry queue lets input run ahead.
// Reset (synchronous, active low) clears held colors, row position, queue and byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module half_block_ansi_rle_encoder
    import hbrle_pkg::*;
#(
    parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hbrle_stream_if.sink     i_pix,
    hbrle_stream_if.source   o_byte
);

    hbrle_stream_if #(.T(t_cmd)) q_in ();
    hbrle_stream_if #(.T(t_cmd)) q_out ();

    // Front: accept and classify pixel pairs.
    hbrle_front #(
        .ROW_PIXELS(ROW_PIXELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_cmd   (q_in)
    );

    // Queue between front and back.
    hbrle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_in),
        .o_cmd   (q_out)
    );

    // Back: emit the byte stream.
    hbrle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_out),
        .o_byte  (o_byte)
    );

endmodule

`default_nettype wire

FILE: bench/tb_half_block_ansi_rle_encoder.sv
`timescale 1ns / 1ps

module tb_half_block_ansi_rle_encoder;
    import hbrle_pkg::*;

    localparam int ROW_PIXELS   = ROW_PIXELS_DEF;
    localparam int TOTAL_PIXELS = 410;

    // Predicts the terminal byte stream and checks the bytes that come out.
    class terminal_stream_scoreboard;
        t_obyte      expected_bytes[$];
        logic [31:0] held_upper;
        logic [31:0] held_lower;
        bit          row_starts;
        int          columns_taken;
        int          errors;

        function new();
            held_upper    = '0;
            held_lower    = '0;
            row_starts    = 1'b1;
            columns_taken = 0;
            errors        = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            t_obyte ob;
            ob.out_byte  = b;
            ob.item_done = 1'b0;
            expected_bytes.push_back(ob);
        endfunction

        function void push_text(string s);
            for (int i = 0; i < s.len(); i++) begin
                push_byte(s[i]);
            end
        endfunction

        // Red, green and blue in decimal without leading zeros; alpha is not printed.
        function void push_color(logic [31:0] c);
            push_text($sformatf("%0d;%0d;%0d", c[7:0], c[15:8], c[23:16]));
        endfunction

        // Works out every byte that one accepted pixel pair causes.
        function void note_pixel(t_pix p);
            logic [31:0] up;
            logic [31:0] lo;
            bit          ends_row;
            t_obyte      last_byte;
            up = {p.upper_alpha, p.upper_blue, p.upper_green, p.upper_red};
            lo = {p.lower_alpha, p.lower_blue, p.lower_green, p.lower_red};
            ends_row = p.row_end || p.frame_end || (columns_taken + 1 >= ROW_PIXELS);

            // A new run opens at a row start or on any change of RGBA.
            if (row_starts || up != held_upper || lo != held_lower) begin
                push_byte(CHR_ESC);
                push_text("[38;2;");
                push_color(up);
                push_text(";48;2;");
                push_color(lo);
                push_byte(CHR_M);
            end
            push_byte(CHR_BLK0);
            push_byte(CHR_BLK1);
            push_byte(CHR_BLK2);
            if (ends_row && !p.frame_end) begin
                push_byte(CHR_NL);
            end

            // The last byte of the item carries the done flag.
            last_byte = expected_bytes.pop_back();
            last_byte.item_done = 1'b1;
            expected_bytes.push_back(last_byte);

            held_upper    = up;
            held_lower    = lo;
            row_starts    = ends_row;
            columns_taken = ends_row ? 0 : columns_taken + 1;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_byte(t_obyte got);
            t_obyte want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %02h arrived with nothing expected", got.out_byte));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
            end
            if (got.item_done !== want.item_done) begin
                report($sformatf("item_done %b, expected %b on byte %02h",
                                 got.item_done, want.item_done, want.out_byte));
            end
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hbrle_stream_if #(.T(t_pix))   pix_if ();
    hbrle_stream_if #(.T(t_obyte)) byte_if ();

    half_block_ansi_rle_encoder #(
        .ROW_PIXELS (ROW_PIXELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_byte  (byte_if)
    );

    terminal_stream_scoreboard stream_sb;
    int burst_left;
    int pixels_sent;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Every accepted output byte goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            stream_sb.check_byte(byte_if.data);
        end
    end

    // The receiver alternates between always ready, random stalls and a slow pattern.
    initial begin
        int mode;
        int len;
        int period;
        byte_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode   = $urandom_range(0, 2);
            len    = $urandom_range(10, 80);
            period = $urandom_range(2, 6);
            for (int k = 0; k < len; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       byte_if.ready = 1'b1;
                    1:       byte_if.ready = 1'($urandom_range(0, 1));
                    default: byte_if.ready = (k % period == 0);
                endcase
            end
        end
    end

    function automatic t_pix make_pixel(logic [7:0] ur, logic [7:0] ug, logic [7:0] ub,
                                        logic [7:0] ua, logic [7:0] lr, logic [7:0] lg,
                                        logic [7:0] lb, logic [7:0] la, logic re, logic fe);
        t_pix p;
        p.upper_red   = ur;
        p.upper_green = ug;
        p.upper_blue  = ub;
        p.upper_alpha = ua;
        p.lower_red   = lr;
        p.lower_green = lg;
        p.lower_blue  = lb;
        p.lower_alpha = la;
        p.row_end     = re;
        p.frame_end   = fe;
        return p;
    endfunction

    // One channel: one, two or three digits, or an extreme value.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 255));
            default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // Upper RGBA in the low word, lower RGBA in the high word.
    function automatic logic [63:0] random_pair();
        logic [63:0] pair;
        for (int i = 0; i < 8; i++) begin
            pair[i*8 +: 8] = random_channel();
        end
        return pair;
    endfunction

    // Sends one item in bursts of random length with random gaps between them.
    task send_pixel(input t_pix p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                pix_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        pix_if.valid = 1'b1;
        pix_if.data  = p;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        stream_sb.note_pixel(p);
        pixels_sent++;
    endtask

    // Holds the sender off until every expected byte has come out.
    task wait_drained();
        @(negedge i_clk);
        pix_if.valid = 1'b0;
        while (stream_sb.pending() != 0) @(negedge i_clk);
    endtask

    // Stimulus: directed items first, then random frames.
    initial begin
        logic [63:0] palette [4];
        logic [63:0] pair;
        int          frame_rows;
        int          row_len;
        int          row_no;
        logic        re;
        logic        fe;

        i_rst_n      = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        stream_sb    = new();
        burst_left   = 0;
        pixels_sent  = 0;
        row_no       = 0;
        pair         = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A first column equal to the reset colors still opens a run.
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Changes in alpha alone open a run.
        send_pixel(make_pixel(0, 0, 0, 255, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(0, 0, 0, 255, 0, 0, 0, 255, 0, 0));
        send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255, 0, 0));
        // Every digit count and the edges between them.
        send_pixel(make_pixel(9, 10, 99, 1, 100, 199, 200, 254, 0, 0));
        send_pixel(make_pixel(9, 10, 99, 1, 100, 199, 200, 254, 1, 0));
        // Same colors across a row boundary.
        send_pixel(make_pixel(9, 10, 99, 1, 100, 199, 200, 254, 0, 0));
        send_pixel(make_pixel(1, 2, 3, 4, 5, 6, 7, 8, 1, 1));
        // Frame end on a one-column row, then in the middle of a row.
        send_pixel(make_pixel(1, 2, 3, 4, 5, 6, 7, 8, 0, 1));
        send_pixel(make_pixel(170, 85, 170, 85, 85, 170, 85, 170, 0, 0));
        send_pixel(make_pixel(170, 85, 170, 85, 85, 170, 85, 170, 0, 0));
        send_pixel(make_pixel(85, 170, 85, 170, 170, 85, 170, 85, 0, 1));
        send_pixel(make_pixel(85, 170, 85, 170, 170, 85, 170, 85, 1, 0));
        send_pixel(make_pixel(128, 64, 32, 16, 8, 4, 2, 1, 1, 0));
        wait_drained();

        // Random frames built from a small palette so that runs repeat.
        while (pixels_sent < TOTAL_PIXELS) begin
            frame_rows = $urandom_range(1, 4);
            for (int i = 0; i < 4; i++) begin
                palette[i] = random_pair();
            end
            for (int r = 0; r < frame_rows && pixels_sent < TOTAL_PIXELS; r++) begin
                // Now and then a row runs past the row length without a mark.
                if (row_no == 2 || $urandom_range(0, 29) == 0) begin
                    row_len = $urandom_range(158, 175);
                end else begin
                    row_len = $urandom_range(1, 12);
                end
                row_no++;
                for (int c = 0; c < row_len && pixels_sent < TOTAL_PIXELS; c++) begin
                    if (c == 0 || $urandom_range(0, 9) < 4) begin
                        pair = ($urandom_range(0, 4) == 0) ? random_pair()
                                                           : palette[$urandom_range(0, 3)];
                    end
                    re = (c == row_len - 1);
                    fe = re && (r == frame_rows - 1);
                    // Stray row and frame marks.
                    if ($urandom_range(0, 19) == 0) begin
                        re = 1'($urandom_range(0, 1));
                        fe = ($urandom_range(0, 3) == 0);
                    end
                    send_pixel(make_pixel(pair[7:0], pair[15:8], pair[23:16], pair[31:24],
                                          pair[39:32], pair[47:40], pair[55:48],
                                          pair[63:56], re, fe));
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (stream_sb.errors == 0 && stream_sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: half_block_ansi_rle_encoder.f
rtl/hbrle_pkg.sv
rtl/hbrle_stream_if.sv
rtl/hbrle_front.sv
rtl/hbrle_fifo.sv
rtl/hbrle_back.sv
rtl/half_block_ansi_rle_encoder.sv
bench/tb_half_block_ansi_rle_encoder.sv
